// ===== sv/acf_pkg.sv =====
package acf_pkg;

  localparam int LINE_BYTES = 256;
  localparam int FILL_W     = $clog2(LINE_BYTES);
  localparam int CMP_W      = (FILL_W > 8) ? FILL_W : 8;
  localparam int KEY_LEN    = 9;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_B    = 8'h42;

  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [FILL_W:0]   ram_addr_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [Q_AW-1:0]   q_ptr_t;
  typedef logic [Q_AW:0]     q_cnt_t;

  localparam fill_t FILL_MAX = fill_t'(LINE_BYTES - 1);

  typedef enum logic [1:0] {
    ACT_RECV       = 2'd0,
    ACT_LINK_RESET = 2'd1,
    ACT_READ       = 2'd2,
    ACT_CLAIM      = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } acf_in_t;

  typedef struct packed {
    logic        line_done;
    logic        line_matched;
    logic        overflowed;
    logic [7:0]  read_data;
    logic        capture_ready;
    logic [7:0]  capture_length;
    logic [31:0] overflow_total;
    logic [31:0] capture_total;
    logic [31:0] other_total;
  } acf_out_t;

  typedef struct packed {
    logic [3:0] progress;
    logic       kw_seen;
    logic       zero_seen;
  } match_t;

  typedef struct packed {
    logic       we;
    ram_addr_t  waddr;
    logic [7:0] wdata;
  } ram_wr_t;

  typedef struct packed {
    logic      re;
    ram_addr_t raddr;
  } ram_rd_t;

  function automatic logic [7:0] keyword_char(logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h42;
      4'd1:    c = 8'h45;
      4'd2:    c = 8'h53;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h50;
      4'd5:    c = 8'h4F;
      4'd6:    c = 8'h53;
      4'd7:    c = 8'h41;
      4'd8:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/acf_byte_ram.sv =====
module acf_byte_ram (
  input  logic             clk,
  input  acf_pkg::ram_wr_t wr,
  input  acf_pkg::ram_rd_t rd,
  output logic [7:0]       rdata
);
  import acf_pkg::*;

  logic [7:0] mem_r [2*LINE_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.waddr] <= wr.wdata;
    end
    if (rd.re) begin
      rdata_r <= mem_r[rd.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/acf_matcher.sv =====
module acf_matcher (
  input  acf_pkg::match_t cur,
  input  logic [7:0]      rx_byte,
  output acf_pkg::match_t nxt
);
  import acf_pkg::*;

  logic [3:0] prog_inc;

  assign prog_inc = cur.progress + 4'd1;

  always_comb begin
    nxt = cur;
    priority if (cur.zero_seen || cur.kw_seen) begin
      nxt = cur;
    end else if (rx_byte == CHAR_NUL) begin
      nxt.zero_seen = 1'b1;
    end else if ((cur.progress < 4'(KEY_LEN)) && (rx_byte == keyword_char(cur.progress))) begin
      nxt.progress = prog_inc;
      nxt.kw_seen  = (prog_inc == 4'(KEY_LEN));
    end else begin
      nxt.progress = (rx_byte == CHAR_B) ? 4'd1 : 4'd0;
    end
  end

endmodule

// ===== sv/acf_out_queue.sv =====
module acf_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  acf_pkg::acf_out_t push_data,
  output acf_pkg::q_cnt_t   level,
  output logic              out_valid,
  input  logic              out_ready,
  output acf_pkg::acf_out_t out_result
);
  import acf_pkg::*;

  acf_out_t q_r [Q_DEPTH];
  q_ptr_t   wr_ptr_r, wr_ptr_nxt;
  q_ptr_t   rd_ptr_r, rd_ptr_nxt;
  q_cnt_t   cnt_r, cnt_nxt;
  logic     pop;

  assign out_valid  = (cnt_r != '0);
  assign out_result = q_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  assign level      = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + q_ptr_t'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + q_ptr_t'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + q_cnt_t'(push) - q_cnt_t'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/ascii_line_capture_filter.sv =====
// Frames received bytes into lines and keeps the latest line holding BESTPOSA, ahead of any
// zero byte. One transaction is accepted per clock while in_ready shows room in the output
// queue; its result passes the byte RAM read register, then the output queue. The line store
// and the capture store are the two halves of one byte RAM with one write and one read port;
// a captured line is not copied, the halves swap roles, so no action needs a copy pass and
// no clearing pass runs after reset. A four-entry output queue decouples in_ready from
// out_ready.
module ascii_line_capture_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  acf_pkg::acf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output acf_pkg::acf_out_t out_result
);
  import acf_pkg::*;

  fill_t       fill_r, fill_nxt;
  match_t      match_r, match_nxt, match_fed;
  logic        line_bank_r, line_bank_nxt;
  fill_t       cap_len_r, cap_len_nxt;
  logic        ready_r, ready_nxt;
  logic [31:0] ovf_cnt_r, ovf_cnt_nxt;
  logic [31:0] cap_cnt_r, cap_cnt_nxt;
  logic [31:0] oth_cnt_r, oth_cnt_nxt;
  logic        p_v_r;
  acf_out_t    p_out_r, p_out_nxt;
  logic        p_hit_r, p_hit_nxt;

  ram_wr_t     ram_wr;
  ram_rd_t     ram_rd;
  logic [7:0]  ram_rdata;
  q_cnt_t      q_level;
  q_cnt_t      inflight;
  acf_out_t    push_data;
  logic        accept;
  cmp_t        idx_ext;
  cmp_t        len_ext;
  fill_t       fill_tmp;
  logic        done, matched, ovf, ready_out;

  assign inflight = q_level + q_cnt_t'(p_v_r);
  assign in_ready = (inflight < q_cnt_t'(Q_DEPTH));
  assign accept   = in_valid && in_ready;
  assign idx_ext  = cmp_t'(in_data.read_index);
  assign len_ext  = cmp_t'(cap_len_r);

  acf_matcher u_matcher (
    .cur     (match_r),
    .rx_byte (in_data.rx_byte),
    .nxt     (match_fed)
  );

  always_comb begin
    fill_nxt      = fill_r;
    match_nxt     = match_r;
    line_bank_nxt = line_bank_r;
    cap_len_nxt   = cap_len_r;
    ready_nxt     = ready_r;
    ovf_cnt_nxt   = ovf_cnt_r;
    cap_cnt_nxt   = cap_cnt_r;
    oth_cnt_nxt   = oth_cnt_r;
    ram_wr.we     = 1'b0;
    ram_wr.waddr  = {line_bank_r, fill_r};
    ram_wr.wdata  = in_data.rx_byte;
    ram_rd.re     = 1'b0;
    ram_rd.raddr  = {~line_bank_r, idx_ext[FILL_W-1:0]};
    p_hit_nxt     = 1'b0;
    fill_tmp      = fill_r;
    done          = 1'b0;
    matched       = 1'b0;
    ovf           = 1'b0;
    ready_out     = ready_r;
    if (accept) begin
      unique case (in_data.action)
        ACT_RECV: begin
          if (in_data.rx_byte != CHAR_CR) begin
            if (fill_r < FILL_MAX) begin
              ram_wr.we = 1'b1;
              fill_tmp  = fill_r + fill_t'(1);
              match_nxt = match_fed;
            end else begin
              ovf         = 1'b1;
              ovf_cnt_nxt = ovf_cnt_r + 32'd1;
              fill_tmp    = '0;
              match_nxt   = '0;
            end
            fill_nxt = fill_tmp;
            if (in_data.rx_byte == CHAR_LF) begin
              if (fill_tmp != '0) begin
                done = 1'b1;
                if (match_nxt.kw_seen) begin
                  matched       = 1'b1;
                  cap_len_nxt   = fill_tmp;
                  ready_nxt     = 1'b1;
                  cap_cnt_nxt   = cap_cnt_r + 32'd1;
                  line_bank_nxt = ~line_bank_r;
                end else begin
                  oth_cnt_nxt = oth_cnt_r + 32'd1;
                end
              end
              fill_nxt  = '0;
              match_nxt = '0;
            end
          end
          ready_out = ready_nxt;
        end
        ACT_LINK_RESET: begin
          fill_nxt  = '0;
          match_nxt = '0;
        end
        ACT_READ: begin
          p_hit_nxt = (idx_ext < len_ext);
          ram_rd.re = p_hit_nxt;
        end
        ACT_CLAIM: begin
          ready_nxt = 1'b0;
        end
        default: begin
          ready_out = ready_r;
        end
      endcase
    end
    p_out_nxt.line_done      = done;
    p_out_nxt.line_matched   = matched;
    p_out_nxt.overflowed     = ovf;
    p_out_nxt.read_data      = '0;
    p_out_nxt.capture_ready  = ready_out;
    p_out_nxt.capture_length = 8'(cap_len_nxt);
    p_out_nxt.overflow_total = ovf_cnt_nxt;
    p_out_nxt.capture_total  = cap_cnt_nxt;
    p_out_nxt.other_total    = oth_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      match_r     <= '0;
      line_bank_r <= 1'b0;
      cap_len_r   <= '0;
      ready_r     <= 1'b0;
      ovf_cnt_r   <= '0;
      cap_cnt_r   <= '0;
      oth_cnt_r   <= '0;
      p_v_r       <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      match_r     <= match_nxt;
      line_bank_r <= line_bank_nxt;
      cap_len_r   <= cap_len_nxt;
      ready_r     <= ready_nxt;
      ovf_cnt_r   <= ovf_cnt_nxt;
      cap_cnt_r   <= cap_cnt_nxt;
      oth_cnt_r   <= oth_cnt_nxt;
      p_v_r       <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_out_r <= p_out_nxt;
      p_hit_r <= p_hit_nxt;
    end
  end

  acf_byte_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (ram_rdata)
  );

  always_comb begin
    push_data           = p_out_r;
    push_data.read_data = p_hit_r ? ram_rdata : 8'h00;
  end

  acf_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (p_v_r),
    .push_data  (push_data),
    .level      (q_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  a_claim_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.action == ACT_CLAIM) |=> !ready_r)
    else $error("ready flag survived a claim");

  a_accept_stages: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> p_v_r)
    else $error("accepted transaction did not reach the read stage");

  a_match_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r && p_out_r.line_matched |-> p_out_r.line_done && p_out_r.capture_ready)
    else $error("match reported without a finished ready line");

  a_overflow_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r && p_out_r.overflowed |-> (fill_r == '0))
    else $error("line did not restart after overflow");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> (q_level < q_cnt_t'(Q_DEPTH)))
    else $error("output queue overrun");

endmodule
